@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros: shared assertion macros
// Clocked, reset-gated concurrent assertion forms.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ hdl/spl_pkg.sv @@
// ----------------------------------------------------------------------------
// spl_pkg: sorted list engine package
// Widths, command and status codes, and the cell control bundle.
// ----------------------------------------------------------------------------
package spl_pkg;

	localparam int CAPACITY_DEF    = 16;
	localparam int VALUE_WIDTH_DEF = 32;

	localparam int CMD_W  = 3;
	localparam int POS_W  = 4;
	localparam int ITEM_W = 32;
	localparam int LEN_W  = 5;
	localparam int STAT_W = 2;

	localparam logic [CMD_W-1:0] CMD_SORT   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_APPEND = 3'd1;
	localparam logic [CMD_W-1:0] CMD_INS_AT = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DEL_AT = 3'd3;
	localparam logic [CMD_W-1:0] CMD_RD_AT  = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_OPEN,
		OP_CLOSE
	} op_t;

	typedef enum logic [1:0] {
		MARK_SORT,
		MARK_POS,
		MARK_END
	} mark_t;

	typedef struct packed {
		op_t   op;
		mark_t mark;
	} ctrl_t;

endpackage

@@ hdl/spl_cell.sv @@
// ----------------------------------------------------------------------------
// spl_cell: one list slot
// Holds one element; finds whether the edit point is at or before it and
// shifts from its left or right neighbor accordingly.
// ----------------------------------------------------------------------------
module spl_cell #(
	parameter int VAL_W = 32,
	parameter int IDX_W = 5,
	parameter int INDEX = 0
) (
	input  logic              clk,
	input  spl_pkg::ctrl_t    ctrl,
	input  logic [IDX_W-1:0]  count,
	input  logic [IDX_W-1:0]  pos,
	input  logic [VAL_W-1:0]  new_val,
	input  logic [VAL_W-1:0]  left_val,
	input  logic [VAL_W-1:0]  right_val,
	input  logic              mark_prev,
	output logic              mark,
	output logic [VAL_W-1:0]  value,
	output logic [VAL_W-1:0]  value_nxt
);
	import spl_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

	logic [VAL_W-1:0] val_q;
	logic             at_end;
	logic             local_mark;

	assign at_end = (MY_IDX >= count);

	always_comb begin
		case (ctrl.mark)
			MARK_SORT: local_mark = at_end | (val_q >= new_val);
			MARK_POS:  local_mark = (MY_IDX >= pos);
			default:   local_mark = at_end;
		endcase
	end

	assign mark = mark_prev | local_mark;

	always_comb begin
		case (ctrl.op)
			OP_OPEN:  value_nxt = mark_prev ? left_val : (mark ? new_val : val_q);
			OP_CLOSE: value_nxt = mark ? right_val : val_q;
			default:  value_nxt = val_q;
		endcase
	end

	always_ff @(posedge clk) begin
		val_q <= value_nxt;
	end

	assign value = val_q;

endmodule

@@ hdl/sorted_positional_list_engine.sv @@
// ----------------------------------------------------------------------------
// sorted_positional_list_engine: ordered list in a row of shifting cells
// One beat per cycle unless a held result stalls the input; each result
// is registered. The mark chain sets each command's next cell row values.
// Reset clears the length and the output valid; element slots are not reset.
// ----------------------------------------------------------------------------
module sorted_positional_list_engine #(
	parameter int CAPACITY    = spl_pkg::CAPACITY_DEF,
	parameter int VALUE_WIDTH = spl_pkg::VALUE_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [spl_pkg::CMD_W-1:0]   cmd,
	input  logic [spl_pkg::POS_W-1:0]   position,
	input  logic [spl_pkg::ITEM_W-1:0]  item_value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [spl_pkg::ITEM_W-1:0]  read_value,
	output logic [spl_pkg::LEN_W-1:0]   list_length,
	output logic [spl_pkg::ITEM_W-1:0]  min_value,
	output logic [spl_pkg::STAT_W-1:0]  status
);
	import spl_pkg::*;

	localparam int SW    = (VALUE_WIDTH < ITEM_W) ? VALUE_WIDTH : ITEM_W;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  cnt_d;
	logic [CMP_W-1:0]  cnt_x;
	logic [CMP_W-1:0]  pos_x;
	logic [SW-1:0]     new_val;
	logic              accept;
	logic              full;
	logic              empty;
	logic              rd_hit;
	logic [STAT_W-1:0] stat_d;
	ctrl_t             ctrl;

	logic [SW-1:0]     vals     [CAPACITY];
	logic [SW-1:0]     nxts     [CAPACITY];
	logic [SW-1:0]     left_arr [CAPACITY];
	logic [SW-1:0]     right_arr[CAPACITY];
	logic              marks    [CAPACITY+1];
	logic [SW-1:0]     rd_mux;

	logic              out_valid_q;
	logic [ITEM_W-1:0] rd_q;
	logic [LEN_W-1:0]  len_q;
	logic [ITEM_W-1:0] min_q;
	logic [STAT_W-1:0] stat_q;

	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;
	assign new_val  = item_value[SW-1:0];
	assign cnt_x    = CMP_W'(cnt_q);
	assign pos_x    = CMP_W'(position);
	assign full     = (cnt_q >= CNT_W'(CAPACITY));
	assign empty    = (cnt_q == '0);

	always_comb begin
		stat_d    = ST_OK;
		rd_hit    = 1'b0;
		ctrl.op   = OP_HOLD;
		ctrl.mark = MARK_END;
		unique case (cmd)
			CMD_SORT: begin
				if (full) stat_d = ST_FULL;
				else begin
					ctrl.op   = OP_OPEN;
					ctrl.mark = MARK_SORT;
				end
			end
			CMD_APPEND: begin
				if (full) stat_d = ST_FULL;
				else ctrl.op = OP_OPEN;
			end
			CMD_INS_AT: begin
				if (full) stat_d = ST_FULL;
				else if (pos_x >= cnt_x) stat_d = ST_RANGE;
				else begin
					ctrl.op   = OP_OPEN;
					ctrl.mark = MARK_POS;
				end
			end
			CMD_DEL_AT: begin
				if (empty) stat_d = ST_EMPTY;
				else if (pos_x >= cnt_x) stat_d = ST_RANGE;
				else begin
					ctrl.op   = OP_CLOSE;
					ctrl.mark = MARK_POS;
				end
			end
			CMD_RD_AT: begin
				if (empty) stat_d = ST_EMPTY;
				else if (pos_x >= cnt_x) stat_d = ST_RANGE;
				else rd_hit = 1'b1;
			end
			default: ;
		endcase
		if (!accept) ctrl.op = OP_HOLD;
	end

	always_comb begin
		case (ctrl.op)
			OP_OPEN:  cnt_d = cnt_q + CNT_W'(1);
			OP_CLOSE: cnt_d = cnt_q - CNT_W'(1);
			default:  cnt_d = cnt_q;
		endcase
	end

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			left_arr[i]  = (i == 0) ? '0 : vals[(i == 0) ? 0 : i - 1];
			right_arr[i] = (i == CAPACITY - 1) ? '0 : vals[(i == CAPACITY - 1) ? i : i + 1];
		end
	end

	assign marks[0] = 1'b0;

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		spl_cell #(
			.VAL_W (SW),
			.IDX_W (CMP_W),
			.INDEX (g)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.count     (cnt_x),
			.pos       (pos_x),
			.new_val   (new_val),
			.left_val  (left_arr[g]),
			.right_val (right_arr[g]),
			.mark_prev (marks[g]),
			.mark      (marks[g+1]),
			.value     (vals[g]),
			.value_nxt (nxts[g])
		);
	end

	always_comb begin
		rd_mux = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (pos_x == CMP_W'(i)) rd_mux = vals[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			cnt_q <= cnt_d;
			if (accept) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q   <= rd_hit ? ITEM_W'(rd_mux) : '0;
			len_q  <= LEN_W'(cnt_d);
			min_q  <= (cnt_d == '0) ? '0 : ITEM_W'(nxts[0]);
			stat_q <= stat_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign read_value  = rd_q;
	assign list_length = len_q;
	assign min_value   = min_q;
	assign status      = stat_q;

endmodule

@@ hdl/spl_checker.sv @@
// ----------------------------------------------------------------------------
// spl_checker: port-level checks for the sorted list engine
// Watches the top-level ports over time; attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spl_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [spl_pkg::ITEM_W-1:0]  read_value,
	input logic [spl_pkg::LEN_W-1:0]   list_length,
	input logic [spl_pkg::ITEM_W-1:0]  min_value,
	input logic [spl_pkg::STAT_W-1:0]  status
);
	import spl_pkg::*;

	// a held result beat stays offered
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)

	// a held result blocks the next input beat
	`ASSERT_IMPL(a_in_blocked, clk, arst_n, out_valid && out_stall, in_stall)

	// empty list reports a zero head
	`ASSERT_IMPL(a_min_empty, clk, arst_n, out_valid && (list_length == '0), min_value == '0)

	// a failed command never returns data
	`ASSERT_IMPL(a_rd_fail, clk, arst_n, out_valid && (status != ST_OK), read_value == '0)

endmodule

bind sorted_positional_list_engine spl_checker u_spl_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.read_value  (read_value),
	.list_length (list_length),
	.min_value   (min_value),
	.status      (status)
);

@@ bench/list_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// list_result_checker: result predictor and scoreboard for the list engine
// Watches both channels, keeps its own copy of the ordered store, predicts
// one report per accepted command beat and compares each result beat with
// the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module list_result_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic [spl_pkg::CMD_W-1:0]   cmd,
	input  logic [spl_pkg::POS_W-1:0]   position,
	input  logic [spl_pkg::ITEM_W-1:0]  item_value,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic [spl_pkg::ITEM_W-1:0]  read_value,
	input  logic [spl_pkg::LEN_W-1:0]   list_length,
	input  logic [spl_pkg::ITEM_W-1:0]  min_value,
	input  logic [spl_pkg::STAT_W-1:0]  status,
	output int                          fail_count,
	output int                          pending,
	output int                          checked_count,
	output int                          full_count,
	output int                          range_count,
	output int                          empty_count
);
	import spl_pkg::*;

	localparam int LIST_DEPTH = CAPACITY_DEF;

	typedef struct {
		logic [ITEM_W-1:0] rd;
		logic [LEN_W-1:0]  len;
		logic [ITEM_W-1:0] head;
		logic [STAT_W-1:0] st;
	} list_report_t;

	logic [ITEM_W-1:0] model_slots [LIST_DEPTH];
	logic [LEN_W-1:0]  model_len;
	list_report_t      predicted_reports [$];
	list_report_t      want;
	int                mismatches = 0;
	int                checked = 0;
	int                fulls = 0;
	int                ranges = 0;
	int                empties = 0;

	initial begin
		fail_count    = 0;
		pending       = 0;
		checked_count = 0;
		full_count    = 0;
		range_count   = 0;
		empty_count   = 0;
	end

	function automatic void open_slot(input int at, input logic [ITEM_W-1:0] value);
		for (int k = model_len; k > at; k--)
			model_slots[k] = model_slots[k-1];
		model_slots[at] = value;
		model_len = model_len + 1'b1;
	endfunction

	function automatic list_report_t apply_list_command(
		input logic [CMD_W-1:0]  op,
		input logic [POS_W-1:0]  at,
		input logic [ITEM_W-1:0] value
	);
		list_report_t r;
		int slot;
		r.rd = '0;
		r.st = ST_OK;
		case (op)
			CMD_SORT: begin
				if (model_len >= LIST_DEPTH) begin
					r.st = ST_FULL;
				end else begin
					slot = 0;
					while (slot < model_len && model_slots[slot] < value)
						slot++;
					open_slot(slot, value);
				end
			end
			CMD_APPEND: begin
				if (model_len >= LIST_DEPTH)
					r.st = ST_FULL;
				else
					open_slot(model_len, value);
			end
			CMD_INS_AT: begin
				if (model_len >= LIST_DEPTH)
					r.st = ST_FULL;
				else if (at >= model_len)
					r.st = ST_RANGE;
				else
					open_slot(at, value);
			end
			CMD_DEL_AT: begin
				if (model_len == 0) begin
					r.st = ST_EMPTY;
				end else if (at >= model_len) begin
					r.st = ST_RANGE;
				end else begin
					for (slot = at; slot + 1 < model_len; slot++)
						model_slots[slot] = model_slots[slot+1];
					model_len = model_len - 1'b1;
				end
			end
			CMD_RD_AT: begin
				if (model_len == 0)
					r.st = ST_EMPTY;
				else if (at >= model_len)
					r.st = ST_RANGE;
				else
					r.rd = model_slots[at];
			end
			default: ;
		endcase
		r.len  = model_len;
		r.head = (model_len != 0) ? model_slots[0] : '0;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model_len = '0;
			predicted_reports.delete();
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (predicted_reports.size() == 0) begin
					$error("result beat with no command outstanding");
					mismatches++;
				end else begin
					want = predicted_reports.pop_front();
					checked++;
					case (want.st)
						ST_FULL:  fulls++;
						ST_RANGE: ranges++;
						ST_EMPTY: empties++;
						default: ;
					endcase
					if (read_value !== want.rd) begin
						$error("read_value mismatch: expected %h, got %h", want.rd, read_value);
						mismatches++;
					end
					if (list_length !== want.len) begin
						$error("list_length mismatch: expected %0d, got %0d",
							want.len, list_length);
						mismatches++;
					end
					if (min_value !== want.head) begin
						$error("min_value mismatch: expected %h, got %h", want.head, min_value);
						mismatches++;
					end
					if (status !== want.st) begin
						$error("status mismatch: expected %0d, got %0d", want.st, status);
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall)
				predicted_reports.push_back(apply_list_command(cmd, position, item_value));
			pending       <= predicted_reports.size();
			fail_count    <= mismatches;
			checked_count <= checked;
			full_count    <= fulls;
			range_count   <= ranges;
			empty_count   <= empties;
		end
	end

endmodule

@@ bench/sorted_positional_list_engine_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_positional_list_engine_test: top level bench for the list engine
// Drives a directed opening (empty list, extreme and equal values, bad
// positions, unused opcodes) and then grow/shrink bursts of random commands
// under four pacing phases, with a drain pause in each phase.
// ----------------------------------------------------------------------------
module sorted_positional_list_engine_test;
	import spl_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int ITEMS_PER_PHASE = 220;
	localparam logic [CMD_W-1:0] CMD_UNUSED_LO = CMD_RD_AT + 1'b1;
	localparam logic [CMD_W-1:0] CMD_UNUSED_HI = '1;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [CMD_W-1:0]  cmd = '0;
	logic [POS_W-1:0]  position = '0;
	logic [ITEM_W-1:0] item_value = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [ITEM_W-1:0] read_value;
	logic [LEN_W-1:0]  list_length;
	logic [ITEM_W-1:0] min_value;
	logic [STAT_W-1:0] status;

	int fail_count;
	int pending;
	int checked_count;
	int full_count;
	int range_count;
	int empty_count;

	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int sent_count = 0;

	always #4 clk = ~clk;

	sorted_positional_list_engine dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.position    (position),
		.item_value  (item_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.read_value  (read_value),
		.list_length (list_length),
		.min_value   (min_value),
		.status      (status)
	);

	list_result_checker result_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.cmd           (cmd),
		.position      (position),
		.item_value    (item_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.read_value    (read_value),
		.list_length   (list_length),
		.min_value     (min_value),
		.status        (status),
		.fail_count    (fail_count),
		.pending       (pending),
		.checked_count (checked_count),
		.full_count    (full_count),
		.range_count   (range_count),
		.empty_count   (empty_count)
	);

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else
			out_stall <= ($urandom_range(99) < receiver_stall_pct);
	end

	task automatic send_command(
		input logic [CMD_W-1:0]  op,
		input logic [POS_W-1:0]  at,
		input logic [ITEM_W-1:0] value
	);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		cmd        <= op;
		position   <= at;
		item_value <= value;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent_count++;
	endtask

	// no-progress watchdog
	initial begin
		int stuck;
		stuck = 0;
		while (stuck < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
				stuck = 0;
			else
				stuck++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		logic [CMD_W-1:0]  op;
		logic [POS_W-1:0]  at;
		logic [ITEM_W-1:0] value;
		int roll;
		bit grow;
		int directed_count;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
				1: begin sender_idle_pct = 66; receiver_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  receiver_stall_pct = 66; end
				default: begin sender_idle_pct = 38; receiver_stall_pct = 38; end
			endcase

			if (phase == 0) begin
				// empty list corner cases
				send_command(CMD_RD_AT, 4'd0, 32'h0);
				send_command(CMD_DEL_AT, 4'd0, 32'h0);
				send_command(CMD_INS_AT, 4'd0, 32'hDEAD_BEEF);
				send_command(CMD_UNUSED_LO, 4'd0, 32'h0);
				// sorted inserts: extremes and an equal key
				send_command(CMD_SORT, 4'd0, 32'hFFFF_FFFF);
				send_command(CMD_SORT, 4'd0, 32'h0000_0000);
				send_command(CMD_SORT, 4'd0, 32'h8000_0000);
				send_command(CMD_SORT, 4'd9, 32'h8000_0000);
				send_command(CMD_APPEND, 4'd0, 32'h0000_0005);
				send_command(CMD_INS_AT, 4'd0, 32'h1234_5678);
				send_command(CMD_INS_AT, 4'd5, 32'h7FFF_FFFF);
				send_command(CMD_INS_AT, 4'd7, 32'h5555_5555);
				send_command(CMD_RD_AT, 4'd0, 32'h0);
				send_command(CMD_RD_AT, 4'd6, 32'h0);
				send_command(CMD_RD_AT, 4'd15, 32'h0);
				send_command(CMD_DEL_AT, 4'd0, 32'h0);
				send_command(CMD_DEL_AT, 4'd5, 32'h0);
				send_command(CMD_DEL_AT, 4'd5, 32'h0);
				send_command(CMD_UNUSED_LO + 1'b1, 4'd3, 32'hAAAA_AAAA);
				send_command(CMD_UNUSED_HI, 4'd15, 32'hFFFF_FFFF);
				directed_count = sent_count;
			end

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				grow = ((n / 40) % 2 == 0);
				roll = $urandom_range(99);
				if (grow) begin
					if (roll < 30)      op = CMD_SORT;
					else if (roll < 50) op = CMD_APPEND;
					else if (roll < 70) op = CMD_INS_AT;
					else if (roll < 80) op = CMD_DEL_AT;
					else if (roll < 95) op = CMD_RD_AT;
					else op = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
				end else begin
					if (roll < 5)       op = CMD_SORT;
					else if (roll < 10) op = CMD_APPEND;
					else if (roll < 15) op = CMD_INS_AT;
					else if (roll < 80) op = CMD_DEL_AT;
					else if (roll < 95) op = CMD_RD_AT;
					else op = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
				end

				if ($urandom_range(99) < 70)
					at = POS_W'($urandom_range(0, 3));
				else
					at = POS_W'($urandom_range(0, 15));

				case ($urandom_range(3))
					0: value = $urandom;
					1: value = $urandom_range(0, 7);
					2: begin
						case ($urandom_range(3))
							0: value = 32'h0000_0000;
							1: value = 32'hFFFF_FFFF;
							2: value = 32'h8000_0000;
							default: value = 32'h7FFF_FFFF;
						endcase
					end
					default: value = {8'($urandom_range(0, 255)), 24'h0} | $urandom_range(0, 3);
				endcase

				send_command(op, at, value);

				// hold off until the engine has answered everything
				if (n == ITEMS_PER_PHASE / 2) begin
					in_valid <= 1'b0;
					@(posedge clk);
					while (pending != 0)
						@(posedge clk);
				end
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);

		$display("Covered %0d commands (%0d directed) in four pacing phases with drain pauses.",
			sent_count, directed_count);
		$display("Checked %0d results: %0d full-list, %0d bad-position, %0d empty-list reports.",
			checked_count, full_count, range_count, empty_count);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
